### sv/idmb_pkg.sv
// Shared types and constants for the inverse-distance move blend.
package idmb_pkg;

  localparam int MaxNeighbours = 10;
  localparam int QueueDepth = 2;
  localparam int DistW = 16;
  localparam int MoveW = 20;
  localparam int MaskW = 9;
  localparam int VtxW = 16;
  localparam int WeightW = 32;
  localparam int SumW = 56;
  localparam int ThreshW = 40;
  localparam logic [WeightW-1:0] ExactWeight = 32'd4096000;
  localparam logic signed [MoveW-1:0] MoveMax = 20'sd524287;
  localparam logic signed [MoveW-1:0] MoveMin = -20'sd524288;

  // Configuration register indexes.
  localparam logic CfgMaskEnable = 1'b0;
  localparam logic CfgMinMoveSq = 1'b1;

  // One neighbour item as the front part hands it to the back part.
  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic [DistW-1:0] distance;
    logic counts;
    logic signed [MoveW-1:0] mx;
    logic signed [MoveW-1:0] my;
    logic signed [MoveW-1:0] mz;
    logic [MaskW-1:0] mask;
    logic last;
  } item_t;

  // Status the divider returns to the back part.
  typedef struct packed {
    logic busy;
    logic done;
  } back_status_t;

endpackage

### sv/idmb_front.sv
// Front part: accepts neighbour items, counts run position, queues them.
module idmb_front #(
  parameter int MAX_NEIGHBOURS = idmb_pkg::MaxNeighbours,
  parameter int QUEUE_DEPTH = idmb_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  idmb_pkg::item_t in_item,
  output logic q_valid,
  input  logic q_take,
  output idmb_pkg::item_t q_item
);
  localparam int PosW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  idmb_pkg::item_t slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic [PosW-1:0] position;
  logic accept;
  idmb_pkg::item_t tagged_item;

  assign in_stall = (fill == QCW'(QUEUE_DEPTH));
  assign accept = in_valid && !in_stall;
  assign q_valid = (fill != '0);
  assign q_item = slots[rd_ptr];

  // Mark whether the item falls within the counted part of its run.
  always_comb begin
    tagged_item = in_item;
    tagged_item.counts = in_item.counts && (position < PosW'(MAX_NEIGHBOURS));
  end

  // Run position and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (accept) begin
        slots[wr_ptr] <= tagged_item;
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        if (in_item.last) begin
          position <= '0;
        end else if (position < PosW'(MAX_NEIGHBOURS)) begin
          position <= position + 1'b1;
        end
      end
      if (q_take) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + QCW'(accept) - QCW'(q_take);
    end
  end
endmodule

### sv/idmb_divider.sv
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
module idmb_divider #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic busy,
  output logic done,
  output logic [NUM_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0] count;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;

  assign trial = {rem[DEN_W-1:0], num_sh[NUM_W-1]};
  assign diff = trial - {1'b0, den};

  // Shift-subtract loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num_sh <= numer;
        den <= denom;
        rem <= '0;
        quot <= '0;
        count <= CW'(NUM_W);
      end else if (busy) begin
        num_sh <= num_sh << 1;
        if (!diff[DEN_W]) begin
          rem <= diff;
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/idmb_back.sv
// Back part: weights and accumulates items, then forms the blended move.
module idmb_back (
  input  logic clk,
  input  logic rst,
  input  logic mask_enable,
  input  logic [idmb_pkg::ThreshW-1:0] min_move_sq,
  input  logic q_valid,
  output logic q_take,
  input  idmb_pkg::item_t q_item,
  output logic res_valid,
  input  logic res_stall,
  output logic [idmb_pkg::VtxW-1:0] res_vertex,
  output logic res_write,
  output logic signed [idmb_pkg::MoveW-1:0] res_x,
  output logic signed [idmb_pkg::MoveW-1:0] res_y,
  output logic signed [idmb_pkg::MoveW-1:0] res_z
);
  localparam int SumW = idmb_pkg::SumW;
  localparam int WW = idmb_pkg::WeightW;
  localparam int MW = idmb_pkg::MoveW;

  typedef enum logic [3:0] {
    S_IDLE, S_RECIP, S_MUL, S_ACC, S_DIV, S_DIVWAIT, S_NEXT,
    S_MASK, S_SQ, S_SUM, S_OUT
  } state_t;

  state_t state;
  idmb_pkg::item_t cur;
  logic [WW-1:0] weight;
  logic [WW-1:0] weight_total;
  logic signed [SumW-1:0] sum [3];
  logic signed [SumW-1:0] prod [3];
  logic signed [MW-1:0] mean [3];
  logic [63:0] sq [3];
  logic [1:0] axis;
  logic neg;
  logic [idmb_pkg::ThreshW+2:0] sq_total;

  // Shared divider.
  logic div_start;
  logic [SumW-1:0] div_num;
  logic [WW-1:0] div_den;
  idmb_pkg::back_status_t div_st;
  logic [SumW-1:0] div_q;
  logic signed [MW-1:0] keep;
  logic signed [SumW-1:0] abs_sum;
  logic signed [SumW:0] signed_q;
  logic signed [MW-1:0] sat_q;
  logic signed [MW+MW-1:0] scaled;
  logic signed [MW+MW-1:0] scaled_div;

  idmb_divider #(.NUM_W(SumW), .DEN_W(WW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num), .denom(div_den),
    .busy(div_st.busy), .done(div_st.done), .quot(div_q)
  );

  assign q_take = (state == S_IDLE) && q_valid;
  assign abs_sum = sum[axis][SumW-1] ? -sum[axis] : sum[axis];

  // Signed quotient, saturated to the move width.
  always_comb begin
    signed_q = neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    if (signed_q > $signed((SumW+1)'(idmb_pkg::MoveMax))) begin
      sat_q = idmb_pkg::MoveMax;
    end else if (signed_q < (SumW+1)'(idmb_pkg::MoveMin)) begin
      sat_q = idmb_pkg::MoveMin;
    end else begin
      sat_q = signed_q[MW-1:0];
    end
    keep = (cur.mask > 9'd256) ? '0 : MW'(10'd256 - {1'b0, cur.mask});
    scaled = mean[axis] * keep;
    scaled_div = (scaled < 0) ? -((-scaled) >>> 8) : (scaled >>> 8);
    sq_total = (idmb_pkg::ThreshW+3)'(sq[0]) + (idmb_pkg::ThreshW+3)'(sq[1])
             + (idmb_pkg::ThreshW+3)'(sq[2]);
  end

  // Divider start: a reciprocal for a counted item with a nonzero distance, or one axis of the mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= ((state == S_IDLE) && q_valid && q_item.counts
                    && (q_item.distance != '0))
                || ((state == S_DIV) && (weight_total != '0));
    end
  end

  // The result is offered from the report step until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (state == S_SUM) || (res_valid && res_stall);
    end
  end

  // Sequencer for accumulation and the final blend.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      weight_total <= '0;
      sum[0] <= '0;
      sum[1] <= '0;
      sum[2] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            state <= q_item.counts ? S_RECIP : S_ACC;
            if (q_item.counts && q_item.distance != '0) begin
              div_num <= SumW'(32'h0100_0000);
              div_den <= WW'(q_item.distance);
            end
          end
        end
        S_RECIP: begin
          if (cur.distance == '0) begin
            weight <= idmb_pkg::ExactWeight;
            state <= S_MUL;
          end else if (div_st.done) begin
            weight <= div_q[WW-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod[0] <= SumW'($signed({1'b0, weight}) * cur.mx);
          prod[1] <= SumW'($signed({1'b0, weight}) * cur.my);
          prod[2] <= SumW'($signed({1'b0, weight}) * cur.mz);
          weight_total <= weight_total + weight;
          state <= S_ACC;
        end
        S_ACC: begin
          if (cur.counts) begin
            sum[0] <= sum[0] + prod[0];
            sum[1] <= sum[1] + prod[1];
            sum[2] <= sum[2] + prod[2];
          end
          axis <= '0;
          state <= cur.last ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (weight_total == '0) begin
            mean[0] <= '0;
            mean[1] <= '0;
            mean[2] <= '0;
            axis <= '0;
            state <= S_MASK;
          end else begin
            div_num <= abs_sum;
            div_den <= weight_total;
            neg <= sum[axis][SumW-1];
            state <= S_DIVWAIT;
          end
        end
        S_DIVWAIT: begin
          if (div_st.done) begin
            mean[axis] <= sat_q;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (axis == 2'd2) begin
            axis <= '0;
            state <= S_MASK;
          end else begin
            axis <= axis + 1'b1;
            state <= S_DIV;
          end
        end
        S_MASK: begin
          if (mask_enable) begin
            mean[axis] <= scaled_div[MW-1:0];
          end
          if (axis == 2'd2) begin
            state <= S_SQ;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_SQ: begin
          sq[0] <= 64'(mean[0] * mean[0]);
          sq[1] <= 64'(mean[1] * mean[1]);
          sq[2] <= 64'(mean[2] * mean[2]);
          state <= S_SUM;
        end
        S_SUM: begin
          if (!res_valid || !res_stall) begin
            res_vertex <= cur.vertex;
            res_write <= (weight_total != '0) && (sq_total >= 43'(min_move_sq));
            if ((weight_total != '0) && (sq_total >= 43'(min_move_sq))) begin
              res_x <= mean[0];
              res_y <= mean[1];
              res_z <= mean[2];
            end else begin
              res_x <= '0;
              res_y <= '0;
              res_z <= '0;
            end
            weight_total <= '0;
            sum[0] <= '0;
            sum[1] <= '0;
            sum[2] <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/inverse_distance_move_blend.sv
// Top level of the inverse-distance move blend.
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | target_vertex .. last_neighbour
//  out     | output    | out_valid/stall  | out_vertex .. blend_z
//  cfg     | input     | cfg_write        | cfg_index, cfg_data
// A counted moving item with a nonzero distance runs through the back part with a
// 56-step bit-serial reciprocal; a zero distance or an uncounted item needs none.
// A last item adds three divisions on the same divider, unless its run has no weight.
// A two-entry queue lets items enter while the back part works.
// Reset is synchronous and clears the run.
// A stalled result holds; the back part then waits before its next result.
module inverse_distance_move_blend #(
  parameter int MAX_NEIGHBOURS = idmb_pkg::MaxNeighbours,
  parameter int QUEUE_DEPTH = idmb_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [idmb_pkg::ThreshW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [15:0] target_vertex,
  input  logic [15:0] distance,
  input  logic has_move,
  input  logic signed [19:0] move_x,
  input  logic signed [19:0] move_y,
  input  logic signed [19:0] move_z,
  input  logic [8:0] mask_level,
  input  logic last_neighbour,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] out_vertex,
  output logic write_move,
  output logic signed [19:0] blend_x,
  output logic signed [19:0] blend_y,
  output logic signed [19:0] blend_z
);
  logic mask_enable;
  logic [idmb_pkg::ThreshW-1:0] min_move_sq;
  idmb_pkg::item_t in_item;
  idmb_pkg::item_t q_item;
  logic q_valid;
  logic q_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_enable <= 1'b1;
      min_move_sq <= idmb_pkg::ThreshW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        idmb_pkg::CfgMaskEnable: mask_enable <= cfg_data[0];
        idmb_pkg::CfgMinMoveSq: min_move_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pack the input transaction.
  always_comb begin
    in_item.vertex = target_vertex;
    in_item.distance = distance;
    in_item.counts = has_move;
    in_item.mx = move_x;
    in_item.my = move_y;
    in_item.mz = move_z;
    in_item.mask = mask_level;
    in_item.last = last_neighbour;
  end

  idmb_front #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  idmb_back u_back (
    .clk(clk), .rst(rst), .mask_enable(mask_enable), .min_move_sq(min_move_sq),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .res_valid(out_valid), .res_stall(out_stall), .res_vertex(out_vertex),
    .res_write(write_move), .res_x(blend_x), .res_y(blend_y), .res_z(blend_z)
  );
endmodule

### sv/idmb_checker.sv
// Port-level checks for the inverse-distance move blend.
module idmb_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic write_move,
  input logic signed [19:0] blend_x,
  input logic signed [19:0] blend_y,
  input logic signed [19:0] blend_z,
  input logic in_stall
);
  // A stalled result stays valid and keeps its x value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(blend_x))
    else $error("stalled result changed");
  // A result without a write carries a zero move.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_move |-> blend_x == 0 && blend_y == 0 && blend_z == 0)
    else $error("non-write result has a move");
  // No result right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
  // Handshake outputs are always known outside reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({out_valid, in_stall}))
    else $error("unknown handshake output");
endmodule

bind inverse_distance_move_blend idmb_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .write_move(write_move), .blend_x(blend_x), .blend_y(blend_y),
  .blend_z(blend_z), .in_stall(in_stall)
);

### verif/inverse_distance_move_blend_checker.sv
// Checker for the inverse-distance move blend: predicts each result and compares it.
`timescale 1ns / 100ps

module inverse_distance_move_blend_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [idmb_pkg::ThreshW-1:0] cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [15:0] target_vertex,
  input  logic [15:0] distance,
  input  logic has_move,
  input  logic signed [19:0] move_x,
  input  logic signed [19:0] move_y,
  input  logic signed [19:0] move_z,
  input  logic [8:0] mask_level,
  input  logic last_neighbour,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [15:0] out_vertex,
  input  logic write_move,
  input  logic signed [19:0] blend_x,
  input  logic signed [19:0] blend_y,
  input  logic signed [19:0] blend_z,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [idmb_pkg::VtxW-1:0] vertex;
    logic wr;
    logic signed [idmb_pkg::MoveW-1:0] bx;
    logic signed [idmb_pkg::MoveW-1:0] by;
    logic signed [idmb_pkg::MoveW-1:0] bz;
  } blend_t;

  blend_t blend_expect_q[$];

  // Shadow configuration and running state of the current run.
  logic mask_on;
  logic [idmb_pkg::ThreshW-1:0] move_floor;
  int unsigned seen_count;
  logic [idmb_pkg::WeightW-1:0] weight_acc;
  longint sum_x, sum_y, sum_z;

  function automatic longint clip20(longint v);
    if (v > longint'(idmb_pkg::MoveMax)) return longint'(idmb_pkg::MoveMax);
    if (v < longint'(idmb_pkg::MoveMin)) return longint'(idmb_pkg::MoveMin);
    return v;
  endfunction

  // Fold one accepted neighbour into the run; close the run on the last flag.
  task automatic accumulate_neighbour();
    logic [idmb_pkg::WeightW-1:0] w;
    longint wt, mx, my, mz, keep, sq;
    blend_t res;
    if (seen_count < idmb_pkg::MaxNeighbours) begin
      if (has_move) begin
        w = (distance == 0) ? idmb_pkg::ExactWeight
                            : idmb_pkg::WeightW'(25'h1000000 / distance);
        weight_acc = weight_acc + w;
        sum_x += longint'({32'b0, w}) * longint'(move_x);
        sum_y += longint'({32'b0, w}) * longint'(move_y);
        sum_z += longint'({32'b0, w}) * longint'(move_z);
      end
      seen_count++;
    end
    if (!last_neighbour) return;
    res = '0;
    res.vertex = target_vertex;
    if (weight_acc != 0) begin
      wt = longint'({32'b0, weight_acc});
      mx = clip20(sum_x / wt);
      my = clip20(sum_y / wt);
      mz = clip20(sum_z / wt);
      if (mask_on) begin
        keep = 256 - ((mask_level > 9'd256) ? 256 : longint'({55'b0, mask_level}));
        mx = (mx * keep) / 256;
        my = (my * keep) / 256;
        mz = (mz * keep) / 256;
      end
      sq = mx * mx + my * my + mz * mz;
      if (sq >= longint'({24'b0, move_floor})) begin
        res.wr = 1'b1;
        res.bx = idmb_pkg::MoveW'(mx);
        res.by = idmb_pkg::MoveW'(my);
        res.bz = idmb_pkg::MoveW'(mz);
      end
    end
    blend_expect_q.insert(blend_expect_q.size(), res);
    seen_count = 0;
    weight_acc = '0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
  endtask

  // Values are sampled at the edge, before the block updates.
  always @(posedge clk) begin
    blend_t exp_r;
    if (rst) begin
      mask_on = 1'b1;
      move_floor = idmb_pkg::ThreshW'(1);
      seen_count = 0;
      weight_acc = '0;
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      blend_expect_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == idmb_pkg::CfgMaskEnable) mask_on = cfg_data[0];
        else if (cfg_index == idmb_pkg::CfgMinMoveSq) move_floor = cfg_data;
      end
      if (in_valid && !in_stall) accumulate_neighbour();
      if (out_valid && !out_stall) begin
        if (blend_expect_q.size() == 0) begin
          $display("%0t: unexpected result vertex %0d", $time, out_vertex);
          errors++;
        end else begin
          exp_r = blend_expect_q.pop_front();
          if (exp_r.vertex !== out_vertex) begin
            $display("%0t: out_vertex expected %0d actual %0d", $time,
                     exp_r.vertex, out_vertex);
            errors++;
          end
          if (exp_r.wr !== write_move) begin
            $display("%0t: write_move expected %0d actual %0d", $time,
                     exp_r.wr, write_move);
            errors++;
          end
          if (exp_r.bx !== blend_x) begin
            $display("%0t: blend_x expected %0d actual %0d", $time, exp_r.bx, blend_x);
            errors++;
          end
          if (exp_r.by !== blend_y) begin
            $display("%0t: blend_y expected %0d actual %0d", $time, exp_r.by, blend_y);
            errors++;
          end
          if (exp_r.bz !== blend_z) begin
            $display("%0t: blend_z expected %0d actual %0d", $time, exp_r.bz, blend_z);
            errors++;
          end
        end
      end
    end
    pending = blend_expect_q.size();
  end

endmodule

### verif/inverse_distance_move_blend_tb.sv
// Testbench top for the inverse-distance move blend: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module inverse_distance_move_blend_tb;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [idmb_pkg::ThreshW-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [15:0] target_vertex, distance;
  logic has_move;
  logic signed [19:0] move_x, move_y, move_z;
  logic [8:0] mask_level;
  logic last_neighbour;
  logic out_valid, out_stall;
  logic [15:0] out_vertex;
  logic write_move;
  logic signed [19:0] blend_x, blend_y, blend_z;
  int errors, pending;

  bit gaps_on = 1'b0;
  bit hold_req = 1'b0;

  always #4 clk = ~clk;

  inverse_distance_move_blend DUT (.*);

  inverse_distance_move_blend_checker chk (.*);

  // Run ends here if the block hangs.
  initial begin
    #40_000_000;
    $display("inverse_distance_move_blend_tb: done, errors");
    $finish;
  end

  // Receiver: random, long or no hold-offs, then takes one transaction.
  initial begin
    int k;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      k = gaps_on ? $urandom_range(0, 17) : 0;
      if (hold_req) begin
        k = 1500;
        hold_req = 1'b0;
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Offer one neighbour transaction and wait until it is taken.
  task automatic send_neighbour(input logic [15:0] v, input logic [15:0] d, input logic hm,
                                input logic [19:0] x, input logic [19:0] y,
                                input logic [19:0] z, input logic [8:0] m,
                                input logic lst);
    int gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    target_vertex <= v;
    distance <= d;
    has_move <= hm;
    move_x <= x;
    move_y <= y;
    move_z <= z;
    mask_level <= m;
    last_neighbour <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Let every result come back, then give the block time to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [idmb_pkg::ThreshW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One random run of neighbours; mostly well formed with small random noise.
  task automatic random_run();
    int len;
    logic [15:0] v, d;
    logic [8:0] m;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 10);
    v = 16'($urandom);
    m = ($urandom_range(0, 2) == 0) ? 9'd0 : 9'($urandom_range(0, 511));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0: d = 16'($urandom_range(0, 16));
        1: d = 16'($urandom_range(0, 255));
        default: d = 16'($urandom);
      endcase
      send_neighbour(($urandom_range(0, 7) == 0) ? 16'($urandom) : v, d,
                     $urandom_range(0, 4) != 0, 20'($urandom), 20'($urandom),
                     20'($urandom), ($urandom_range(0, 7) == 0) ? 9'($urandom) : m,
                     i == len - 1);
    end
  endtask

  initial begin
    logic [idmb_pkg::ThreshW-1:0] thr;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= idmb_pkg::CfgMaskEnable;
    cfg_data <= '0;
    in_valid <= 1'b0;
    target_vertex <= '0;
    distance <= '0;
    has_move <= 1'b0;
    move_x <= '0;
    move_y <= '0;
    move_z <= '0;
    mask_level <= '0;
    last_neighbour <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, exact match, extremes, masking and special runs.
    send_neighbour(16'd1, 16'd0, 1'b1, 20'h7FFFF, 20'h80000, 20'h00001, 9'd0, 1'b1);
    send_neighbour(16'd2, 16'd1, 1'b1, 20'h80000, 20'h7FFFF, 20'hFFFFF, 9'd128, 1'b1);
    send_neighbour(16'hFFFF, 16'hFFFF, 1'b1, 20'h12345, 20'hABCDE, 20'h7FFFF, 9'd255, 1'b1);
    send_neighbour(16'd4, 16'd100, 1'b1, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 9'd256, 1'b1);
    send_neighbour(16'd5, 16'd100, 1'b1, 20'h40000, 20'h40000, 20'h40000, 9'h1FF, 1'b1);
    // No moving neighbour in the run.
    send_neighbour(16'd6, 16'd7, 1'b0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 9'd0, 1'b0);
    send_neighbour(16'd6, 16'd0, 1'b0, 20'h80000, 20'h80000, 20'h80000, 9'd0, 1'b1);
    // More neighbours than counted, mixed vertices, last flag beyond the limit.
    for (int i = 0; i < 12; i++)
      send_neighbour(16'(7 + i % 2), 16'(4096 + i), 1'b1, 20'(i * 1000),
                     20'(-i * 3000), 20'(i * 77), 9'(i * 30), i == 11);
    drain();
    write_reg(idmb_pkg::CfgMaskEnable, 40'd0);
    write_reg(idmb_pkg::CfgMinMoveSq, 40'hFF_FFFF_FFFF);
    send_neighbour(16'd20, 16'd0, 1'b1, 20'h7FFFF, 20'h80000, 20'h80000, 9'd256, 1'b1);
    send_neighbour(16'd21, 16'd2, 1'b1, 20'h00010, 20'h00000, 20'h00000, 9'd0, 1'b1);
    drain();

    // Random phases with changing settings and idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: thr = '0;
        1: thr = idmb_pkg::ThreshW'(1);
        2: thr = idmb_pkg::ThreshW'(1) << $urandom_range(0, 39);
        default: thr = idmb_pkg::ThreshW'({$urandom, $urandom});
      endcase
      if (ph == 7) thr = 40'hFF_FFFF_FFFF;
      write_reg(idmb_pkg::CfgMaskEnable, idmb_pkg::ThreshW'($urandom_range(0, 1)));
      write_reg(idmb_pkg::CfgMinMoveSq, thr);
      gaps_on = (ph % 3) != 1;
      for (int r = 0; r < 30; r++) begin
        if (ph == 2 && r == 3) hold_req = 1'b1;
        random_run();
      end
      drain();
    end
    gaps_on = 1'b0;
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("inverse_distance_move_blend_tb: done, clean");
    end else begin
      $display("inverse_distance_move_blend_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/idmb_pkg.sv
sv/idmb_front.sv
sv/idmb_divider.sv
sv/idmb_back.sv
sv/inverse_distance_move_blend.sv
sv/idmb_checker.sv
verif/inverse_distance_move_blend_checker.sv
verif/inverse_distance_move_blend_tb.sv
